### hw/rtl/im2col_ag_pkg.sv
// ----------------------------------------------------------------------------
// im2col_ag_pkg
// Shared types and constants for the im2col address generator: register
// indexes, decoded configuration, the queued tap record and back-end states.
// ----------------------------------------------------------------------------
package im2col_ag_pkg;

    localparam int ADDR_BITS_DEF = 40;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int CHAN_MAX      = 4096;

    // signed width of iy and ix: 16x8 product plus kernel offset plus sign
    localparam int TAP_W = 26;
    // width of the source address sum before it is cut to the address width
    localparam int SRC_W = 48;

    localparam logic [15:0] KERNEL_RESET = 16'h0303;
    localparam logic [15:0] STRIDE_RESET = 16'h0101;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KERNEL  = 3'd0,
        CFG_STRIDE  = 3'd1,
        CFG_PAD     = 3'd2,
        CFG_IMAGE   = 3'd3,
        CFG_RESULT  = 3'd4,
        CFG_CHANNEL = 3'd5,
        CFG_LAYOUT  = 3'd6
    } cfg_index_t;

    typedef enum logic {
        LAYOUT_PLANAR = 1'b0,
        LAYOUT_CLAST  = 1'b1
    } layout_t;

    // decoded configuration; counts of zero already raised to one
    typedef struct packed {
        logic [7:0]  kh_n;
        logic [7:0]  kw_n;
        logic [7:0]  sh;
        logic [7:0]  sw;
        logic [7:0]  ph;
        logic [7:0]  pw;
        logic [15:0] ih;
        logic [15:0] iw;
        logic [15:0] oh_n;
        logic [15:0] ow_n;
        logic [12:0] c_n;
        layout_t     layout;
    } cfg_t;

    // one element's loop position as classified by the front end
    typedef struct packed {
        logic [11:0] chan;
        logic [7:0]  krow;
        logic [7:0]  kcol;
        logic [15:0] orow;
        logic [15:0] ocol;
        logic        last;
    } tap_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_TAP,
        BK_BOUND,
        BK_PIX,
        BK_PROD,
        BK_FIN
    } bk_state_t;

endpackage

### hw/rtl/im2col_ag_front.sv
// ----------------------------------------------------------------------------
// im2col_ag_front
// Accepts requests, walks the loop counters in the selected layout order and
// pushes each element's position and running index into the queue.
// ----------------------------------------------------------------------------
module im2col_ag_front #(
    parameter int ADDR_BITS = im2col_ag_pkg::ADDR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  im2col_ag_pkg::cfg_t   cfg,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_restart,
    input  logic                  q_full,
    output logic                  q_push,
    output im2col_ag_pkg::tap_t   q_tap,
    output logic [ADDR_BITS-1:0]  q_pos
);
    import im2col_ag_pkg::*;

    logic [11:0]          chan_reg, chan_next;
    logic [7:0]           krow_reg, krow_next;
    logic [7:0]           kcol_reg, kcol_next;
    logic [15:0]          orow_reg, orow_next;
    logic [15:0]          ocol_reg, ocol_next;
    logic [ADDR_BITS-1:0] pos_reg, pos_next;

    logic [11:0]          chan_cur;
    logic [7:0]           krow_cur, kcol_cur;
    logic [15:0]          orow_cur, ocol_cur;
    logic [ADDR_BITS-1:0] pos_cur;

    logic e_chan, e_krow, e_kcol, e_orow, e_ocol, last;
    logic a_chan, a_krow, a_kcol, a_orow, a_ocol;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // restart walks from the origin for this very element
    assign chan_cur = s_restart ? '0 : chan_reg;
    assign krow_cur = s_restart ? '0 : krow_reg;
    assign kcol_cur = s_restart ? '0 : kcol_reg;
    assign orow_cur = s_restart ? '0 : orow_reg;
    assign ocol_cur = s_restart ? '0 : ocol_reg;
    assign pos_cur  = s_restart ? '0 : pos_reg;

    // a counter at or past its limit counts as being on its last value
    assign e_chan = ({1'b0, chan_cur} + 13'd1) >= cfg.c_n;
    assign e_krow = ({1'b0, krow_cur} + 9'd1)  >= {1'b0, cfg.kh_n};
    assign e_kcol = ({1'b0, kcol_cur} + 9'd1)  >= {1'b0, cfg.kw_n};
    assign e_orow = ({1'b0, orow_cur} + 17'd1) >= {1'b0, cfg.oh_n};
    assign e_ocol = ({1'b0, ocol_cur} + 17'd1) >= {1'b0, cfg.ow_n};
    assign last   = e_chan && e_krow && e_kcol && e_orow && e_ocol;

    always_comb begin
        unique case (cfg.layout)
            LAYOUT_CLAST: begin
                a_chan = 1'b1;
                a_kcol = e_chan;
                a_krow = e_chan && e_kcol;
                a_ocol = e_chan && e_kcol && e_krow;
                a_orow = e_chan && e_kcol && e_krow && e_ocol;
            end
            default: begin
                a_ocol = 1'b1;
                a_orow = e_ocol;
                a_kcol = e_ocol && e_orow;
                a_krow = e_ocol && e_orow && e_kcol;
                a_chan = e_ocol && e_orow && e_kcol && e_krow;
            end
        endcase
    end

    always_comb begin
        if (last) begin
            chan_next = '0;
            krow_next = '0;
            kcol_next = '0;
            orow_next = '0;
            ocol_next = '0;
            pos_next  = '0;
        end else begin
            chan_next = a_chan ? (e_chan ? '0 : chan_cur + 12'd1) : chan_cur;
            krow_next = a_krow ? (e_krow ? '0 : krow_cur + 8'd1)  : krow_cur;
            kcol_next = a_kcol ? (e_kcol ? '0 : kcol_cur + 8'd1)  : kcol_cur;
            orow_next = a_orow ? (e_orow ? '0 : orow_cur + 16'd1) : orow_cur;
            ocol_next = a_ocol ? (e_ocol ? '0 : ocol_cur + 16'd1) : ocol_cur;
            pos_next  = pos_cur + ADDR_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg <= '0;
            krow_reg <= '0;
            kcol_reg <= '0;
            orow_reg <= '0;
            ocol_reg <= '0;
            pos_reg  <= '0;
        end else if (q_push) begin
            chan_reg <= chan_next;
            krow_reg <= krow_next;
            kcol_reg <= kcol_next;
            orow_reg <= orow_next;
            ocol_reg <= ocol_next;
            pos_reg  <= pos_next;
        end
    end

    always_comb begin
        q_tap.chan = chan_cur;
        q_tap.krow = krow_cur;
        q_tap.kcol = kcol_cur;
        q_tap.orow = orow_cur;
        q_tap.ocol = ocol_cur;
        q_tap.last = last;
    end
    assign q_pos = pos_cur;

endmodule

### hw/rtl/im2col_ag_queue.sv
// ----------------------------------------------------------------------------
// im2col_ag_queue
// Short first-in first-out queue between the counter walk and the address
// arithmetic.
// ----------------------------------------------------------------------------
module im2col_ag_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    import im2col_ag_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/im2col_ag_back.sv
// ----------------------------------------------------------------------------
// im2col_ag_back
// Takes one queued element at a time, works out the image coordinates, the
// padding flag and the source address over a short multiply sequence, and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module im2col_ag_back #(
    parameter int ADDR_BITS = im2col_ag_pkg::ADDR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  im2col_ag_pkg::cfg_t   cfg,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  im2col_ag_pkg::tap_t   q_tap,
    input  logic [ADDR_BITS-1:0]  q_pos,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ADDR_BITS-1:0]  m_src_addr,
    output logic [ADDR_BITS-1:0]  m_dst_index,
    output logic                  m_pad_zero,
    output logic                  m_last_element
);
    import im2col_ag_pkg::*;

    localparam int SUM_W = (ADDR_BITS > SRC_W) ? ADDR_BITS : SRC_W;

    bk_state_t state_reg, state_next;
    logic      out_load;

    tap_t                 tap_reg;
    logic [ADDR_BITS-1:0] pos_reg;
    logic [23:0]          prod_y_reg, prod_x_reg;
    logic [TAP_W-1:0]     iy_reg, ix_reg;
    logic                 pad_reg;
    logic [31:0]          hw_reg, iyw_reg;
    logic [15:0]          ix_lo_reg;
    logic [32:0]          pix_reg;
    logic [43:0]          cw_reg;
    logic [45:0]          prod2_reg;
    logic [SRC_W-1:0]     src_sum;
    logic [SUM_W-1:0]     src_wide;
    logic                 iy_neg, ix_neg;

    logic                 m_valid_reg;
    logic [ADDR_BITS-1:0] m_src_reg, m_dst_reg;
    logic                 m_pad_reg, m_last_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (!q_empty) state_next = BK_TAP;
            BK_TAP:   state_next = BK_BOUND;
            BK_BOUND: state_next = BK_PIX;
            BK_PIX:   state_next = BK_PROD;
            BK_PROD:  state_next = BK_FIN;
            BK_FIN:   if (!m_valid_reg || m_ready) state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = (state_reg == BK_IDLE) && !q_empty;
        out_load = (state_reg == BK_FIN) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // top bit of the tap coordinate is its sign
    assign iy_neg = iy_reg[TAP_W-1];
    assign ix_neg = ix_reg[TAP_W-1];

    always_comb begin
        if (cfg.layout == LAYOUT_CLAST) begin
            src_sum = SRC_W'(prod2_reg) + SRC_W'(tap_reg.chan);
        end else begin
            src_sum = SRC_W'(cw_reg) + SRC_W'(pix_reg);
        end
        src_wide = SUM_W'(src_sum);
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            tap_reg    <= q_tap;
            pos_reg    <= q_pos;
            prod_y_reg <= 24'(q_tap.orow) * 24'(cfg.sh);
            prod_x_reg <= 24'(q_tap.ocol) * 24'(cfg.sw);
        end
        if (state_reg == BK_TAP) begin
            iy_reg <= TAP_W'(prod_y_reg) - TAP_W'(cfg.ph) + TAP_W'(tap_reg.krow);
            ix_reg <= TAP_W'(prod_x_reg) - TAP_W'(cfg.pw) + TAP_W'(tap_reg.kcol);
        end
        if (state_reg == BK_BOUND) begin
            pad_reg   <= iy_neg || ix_neg || (iy_reg >= TAP_W'(cfg.ih))
                         || (ix_reg >= TAP_W'(cfg.iw));
            hw_reg    <= 32'(cfg.ih) * 32'(cfg.iw);
            iyw_reg   <= 32'(iy_reg[15:0]) * 32'(cfg.iw);
            ix_lo_reg <= ix_reg[15:0];
        end
        if (state_reg == BK_PIX) begin
            pix_reg <= 33'(iyw_reg) + 33'(ix_lo_reg);
            cw_reg  <= 44'(tap_reg.chan) * 44'(hw_reg);
        end
        if (state_reg == BK_PROD) begin
            prod2_reg <= 46'(pix_reg) * 46'(cfg.c_n);
        end
        if (out_load) begin
            m_src_reg  <= pad_reg ? '0 : src_wide[ADDR_BITS-1:0];
            m_dst_reg  <= pos_reg;
            m_pad_reg  <= pad_reg;
            m_last_reg <= tap_reg.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_src_addr     = m_src_reg;
    assign m_dst_index    = m_dst_reg;
    assign m_pad_zero     = m_pad_reg;
    assign m_last_element = m_last_reg;

endmodule

### hw/rtl/im2col_address_generator_unit.sv
// ----------------------------------------------------------------------------
// im2col_address_generator_unit
// Unfolded-matrix address generator: source address, destination index,
// padding flag and end mark for each requested element.
//
//   channel   direction  content
//   s_        in         restart flag, one element per request
//   m_        out        src_addr, dst_index, pad_zero, last_element
//   cfg_      in         register write: index, data, write enable
//
// The front end takes one request per cycle while its 4-entry queue has room.
// Each element then passes through the back end's multiply
// sequence (stride products, coordinates, bounds and row product, pixel and
// plane product, channel product, final sum into the output register).
// Reset clears the counters and the queue and loads the register defaults.
// A stalled output holds the back end; the queue fills and s_ready drops.
// ----------------------------------------------------------------------------
module im2col_address_generator_unit #(
    parameter int ADDR_BITS = im2col_ag_pkg::ADDR_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [im2col_ag_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [im2col_ag_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_restart,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ADDR_BITS-1:0]                  m_src_addr,
    output logic [ADDR_BITS-1:0]                  m_dst_index,
    output logic                                  m_pad_zero,
    output logic                                  m_last_element
);
    import im2col_ag_pkg::*;

    localparam int Q_W = $bits(tap_t) + ADDR_BITS;

    logic [15:0] kernel_reg, stride_reg, pad_reg;
    logic [31:0] image_reg, result_reg;
    logic [12:0] channel_reg;
    logic        layout_reg;
    cfg_t        cfg;

    logic                 q_push, q_pop, q_full, q_empty;
    tap_t                 f_tap, b_tap;
    logic [ADDR_BITS-1:0] f_pos, b_pos;
    logic [Q_W-1:0]       q_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg  <= KERNEL_RESET;
            stride_reg  <= STRIDE_RESET;
            pad_reg     <= '0;
            image_reg   <= '0;
            result_reg  <= '0;
            channel_reg <= 13'd1;
            layout_reg  <= LAYOUT_PLANAR;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_KERNEL:  kernel_reg  <= cfg_wdata[15:0];
                CFG_STRIDE:  stride_reg  <= cfg_wdata[15:0];
                CFG_PAD:     pad_reg     <= cfg_wdata[15:0];
                CFG_IMAGE:   image_reg   <= cfg_wdata[31:0];
                CFG_RESULT:  result_reg  <= cfg_wdata[31:0];
                CFG_CHANNEL: channel_reg <= cfg_wdata[12:0];
                CFG_LAYOUT:  layout_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // zero counts act as one, channel count saturates
    always_comb begin
        cfg.kh_n   = (kernel_reg[15:8] == '0) ? 8'd1 : kernel_reg[15:8];
        cfg.kw_n   = (kernel_reg[7:0] == '0) ? 8'd1 : kernel_reg[7:0];
        cfg.sh     = stride_reg[15:8];
        cfg.sw     = stride_reg[7:0];
        cfg.ph     = pad_reg[15:8];
        cfg.pw     = pad_reg[7:0];
        cfg.ih     = image_reg[31:16];
        cfg.iw     = image_reg[15:0];
        cfg.oh_n   = (result_reg[31:16] == '0) ? 16'd1 : result_reg[31:16];
        cfg.ow_n   = (result_reg[15:0] == '0) ? 16'd1 : result_reg[15:0];
        if (channel_reg == '0) begin
            cfg.c_n = 13'd1;
        end else if (channel_reg > 13'(CHAN_MAX)) begin
            cfg.c_n = 13'(CHAN_MAX);
        end else begin
            cfg.c_n = channel_reg;
        end
        cfg.layout = layout_t'(layout_reg);
    end

    im2col_ag_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_tap     (f_tap),
        .q_pos     (f_pos)
    );

    im2col_ag_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_pos, f_tap}),
        .pop       (q_pop),
        .pop_data  (q_rd_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign b_tap = tap_t'(q_rd_data[$bits(tap_t)-1:0]);
    assign b_pos = q_rd_data[Q_W-1:$bits(tap_t)];

    im2col_ag_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .q_tap          (b_tap),
        .q_pos          (b_pos),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_src_addr     (m_src_addr),
        .m_dst_index    (m_dst_index),
        .m_pad_zero     (m_pad_zero),
        .m_last_element (m_last_element)
    );

    // a padded tap never carries an address
    a_pad_src_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pad_zero) |-> (m_src_addr == '0))
        else $error("padded element with nonzero source address");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    // a new output is only loaded once the previous one has gone
    a_out_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("output request dropped while stalled");

endmodule
